// File: src/pac_pkg.sv
// Package for the PI controller: shared widths, register indexes, state and command types.
package pac_pkg;

    localparam int DATA_W  = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 33;
    localparam int SHIFT_W = 5;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_OUT_LOWER   = 3'd2;
    localparam logic [IDX_W-1:0] REG_OUT_UPPER   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SCALE_SHIFT = 3'd4;

    localparam logic [SHIFT_W-1:0] SHIFT_TO_ZERO = 5'd31;

    localparam logic signed [DATA_W-1:0] OUT_LOWER_RESET = 16'sh8000;
    localparam logic signed [DATA_W-1:0] OUT_UPPER_RESET = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] ERR_MAX  = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] ERR_MIN  = 16'sh8000;
    localparam logic signed [DATA_W-1:0] CAND_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] CAND_MIN = 16'sh8001;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_CLAMP
    } pac_state_t;

    typedef struct packed {
        logic load;
        logic use_integ;
        logic mul_en;
        logic sum_en;
        logic scale_en;
        logic integ_wr;
        logic out_load;
    } pac_cmd_t;

    typedef struct packed {
        logic store;
        logic out_free;
    } pac_status_t;

endpackage

// File: src/pi_controller_anti_windup.sv
// Top level of the PI controller with conditional-integration anti-windup.
//
// Input channel: reference and feedback, taken when in_valid is high and in_stall low.
// Output channel: drive, delivered when out_valid is high and out_stall low.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 proportional gain,
// 1 integral gain, 2 lower bound, 3 upper bound, 4 scale shift); unknown indexes are
// ignored. Write only while the block is idle.
// One transaction is processed at a time. After acceptance it passes through the MUL,
// SUM, SCALE and CLAMP states, and the result is registered in CLAMP when the candidate
// integral is kept; when it is rejected the shared multiply, sum, scale and clamp
// sequence runs a second time before the result is registered. The next input
// transaction is taken only in the idle state that follows, so a new item cannot enter
// before the last one's result is registered; the pair of 16x16 multipliers is reused by both passes.
// Reset clears the integrator to zero, restores the register defaults and empties
// the output register. If the receiver stalls, the finished result stays in the
// output register; the next item is still accepted and completes, then waits in its
// final step until the output register is free.
module pi_controller_anti_windup (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pac_pkg::IDX_W-1:0]            cfg_index,
    input  logic [pac_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [pac_pkg::DATA_W-1:0]    reference,
    input  logic signed [pac_pkg::DATA_W-1:0]    feedback,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pac_pkg::DATA_W-1:0]    drive
);
    import pac_pkg::*;

    pac_cmd_t    cmd;
    pac_status_t status;

    pac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pac_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .reference (reference),
        .feedback  (feedback),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive)
    );

endmodule

// File: src/pac_ctrl.sv
// Controller state machine that sequences the PI datapath.
module pac_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pac_pkg::pac_status_t status,
    output pac_pkg::pac_cmd_t    cmd
);
    import pac_pkg::*;

    pac_state_t state_reg, state_next;
    logic       second_reg, second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    // Next state. A second pass recomputes the output from the old integrator.
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next  = ST_MUL;
                    second_next = 1'b0;
                end
            end
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_CLAMP;
            ST_CLAMP:
            begin
                if (second_reg || status.store)
                begin
                    if (status.out_free)
                        state_next = ST_IDLE;
                end
                else
                begin
                    state_next  = ST_MUL;
                    second_next = 1'b1;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_MUL:
            begin
                cmd.mul_en    = 1'b1;
                cmd.use_integ = second_reg;
            end
            ST_SUM:   cmd.sum_en   = 1'b1;
            ST_SCALE: cmd.scale_en = 1'b1;
            ST_CLAMP:
            begin
                if ((second_reg || status.store) && status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.integ_wr = !second_reg;
                end
            end
            default:  cmd = '0;
        endcase
    end

endmodule

// File: src/pac_datapath.sv
// Datapath of the PI controller: configuration registers, integrator, arithmetic and output register.
module pac_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pac_pkg::IDX_W-1:0]            cfg_index,
    input  logic [pac_pkg::DATA_W-1:0]           cfg_data,
    input  logic signed [pac_pkg::DATA_W-1:0]    reference,
    input  logic signed [pac_pkg::DATA_W-1:0]    feedback,
    input  pac_pkg::pac_cmd_t                    cmd,
    output pac_pkg::pac_status_t                 status,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pac_pkg::DATA_W-1:0]    drive
);
    import pac_pkg::*;

    logic signed [DATA_W-1:0]  prop_gain_reg, integ_gain_reg;
    logic signed [DATA_W-1:0]  out_lower_reg, out_upper_reg;
    logic [SHIFT_W-1:0]        scale_shift_reg;
    logic signed [DATA_W-1:0]  integ_reg;
    logic signed [DATA_W-1:0]  err_reg, cand_reg;
    logic signed [PROD_W-1:0]  prod_p_reg, prod_i_reg;
    logic signed [SUM_W-1:0]   sum_reg, scaled_reg;
    logic signed [DATA_W-1:0]  drive_reg;
    logic                      out_valid_reg;

    logic signed [DATA_W:0]    diff, cand_sum;
    logic signed [DATA_W-1:0]  err_next, cand_next, op_i;
    logic [SUM_W-1:0]          mag, shifted;
    logic signed [SUM_W-1:0]   scaled_next, lower_ext, upper_ext;
    logic                      below, above, err_pos;
    logic signed [DATA_W-1:0]  clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            out_lower_reg   <= OUT_LOWER_RESET;
            out_upper_reg   <= OUT_UPPER_RESET;
            scale_shift_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data;
                REG_OUT_LOWER:   out_lower_reg   <= cfg_data;
                REG_OUT_UPPER:   out_upper_reg   <= cfg_data;
                REG_SCALE_SHIFT: scale_shift_reg <= cfg_data[SHIFT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Saturated error and the clamped candidate integral.
    always_comb
    begin
        diff = {reference[DATA_W-1], reference} - {feedback[DATA_W-1], feedback};
        if (diff > $signed({ERR_MAX[DATA_W-1], ERR_MAX}))
            err_next = ERR_MAX;
        else if (diff < $signed({ERR_MIN[DATA_W-1], ERR_MIN}))
            err_next = ERR_MIN;
        else
            err_next = diff[DATA_W-1:0];

        cand_sum = {integ_reg[DATA_W-1], integ_reg} + {err_next[DATA_W-1], err_next};
        if (cand_sum < $signed({CAND_MIN[DATA_W-1], CAND_MIN}))
            cand_next = CAND_MIN;
        else if (cand_sum > $signed({CAND_MAX[DATA_W-1], CAND_MAX}))
            cand_next = CAND_MAX;
        else
            cand_next = cand_sum[DATA_W-1:0];
    end

    assign op_i = cmd.use_integ ? integ_reg : cand_reg;

    // The magnitude is shifted so that negative values truncate toward zero.
    always_comb
    begin
        mag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        shifted = mag >> scale_shift_reg;
        if (scale_shift_reg == SHIFT_TO_ZERO)
            scaled_next = '0;
        else if (sum_reg[SUM_W-1])
            scaled_next = -$signed(shifted);
        else
            scaled_next = $signed(shifted);
    end

    // Clamp, lower bound first, and the integrator hold decision.
    always_comb
    begin
        lower_ext = {{(SUM_W-DATA_W){out_lower_reg[DATA_W-1]}}, out_lower_reg};
        upper_ext = {{(SUM_W-DATA_W){out_upper_reg[DATA_W-1]}}, out_upper_reg};
        below     = scaled_reg < lower_ext;
        above     = scaled_reg > upper_ext;
        err_pos   = !err_reg[DATA_W-1] && (err_reg != '0);
        if (below)
            clamped = out_lower_reg;
        else if (above)
            clamped = out_upper_reg;
        else
            clamped = scaled_reg[DATA_W-1:0];
        status.store = (!below && !above) || (integ_gain_reg == '0)
                     || (above && err_reg[DATA_W-1]) || (below && err_pos);
        status.out_free = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.integ_wr)
                integ_reg <= cand_reg;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg  <= err_next;
            cand_reg <= cand_next;
        end
        if (cmd.mul_en)
        begin
            prod_p_reg <= prop_gain_reg * err_reg;
            prod_i_reg <= integ_gain_reg * op_i;
        end
        if (cmd.sum_en)
            sum_reg <= {prod_p_reg[PROD_W-1], prod_p_reg}
                     + {prod_i_reg[PROD_W-1], prod_i_reg};
        if (cmd.scale_en)
            scaled_reg <= scaled_next;
        if (cmd.out_load)
            drive_reg <= clamped;
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule
